// ----- rtl/swept_aabb_collision_test_unit_defines.svh -----
// Assertion macros shared by the swept box contact test RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef SWEPT_AABB_COLLISION_TEST_UNIT_DEFINES_SVH
`define SWEPT_AABB_COLLISION_TEST_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SAABB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SAABB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SAABB_ASSERT(lbl, prop, msg)
`define SAABB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/saabb_pkg.sv -----
// Shared constants and types for the swept box contact test.
// Depends on nothing.
`timescale 1ns / 1ps
package saabb_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAME_WIDTH     = 20;
    localparam int QUO_BITS        = 20;
    localparam int TIME_WIDTH      = QUO_BITS + 1;
    localparam logic [FRAME_WIDTH-1:0] FRAME_RESET = FRAME_WIDTH'(1092);
    localparam logic [TIME_WIDTH-1:0]  TIME_SAT    = TIME_WIDTH'(1) << QUO_BITS;

    typedef struct packed {
        logic stat;
        logic missx;
        logic missy;
        logic enx;
        logic exx;
        logic eny;
        logic exy;
    } t_flags;
endpackage

// ----- rtl/saabb_ifs.sv -----
// Handshake channel interfaces for the swept box contact test.
// Depends on saabb_pkg.
`timescale 1ns / 1ps
interface saabb_in_if #(parameter int COORD_WIDTH = saabb_pkg::COORD_WIDTH_DEF);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] a_min_x, a_min_y, a_max_x, a_max_y, a_vel_x, a_vel_y;
    logic signed [COORD_WIDTH-1:0] b_min_x, b_min_y, b_max_x, b_max_y, b_vel_x, b_vel_y;
    modport source (output valid, a_min_x, a_min_y, a_max_x, a_max_y, a_vel_x, a_vel_y,
                    b_min_x, b_min_y, b_max_x, b_max_y, b_vel_x, b_vel_y, input ready);
    modport sink (input valid, a_min_x, a_min_y, a_max_x, a_max_y, a_vel_x, a_vel_y,
                  b_min_x, b_min_y, b_max_x, b_max_y, b_vel_x, b_vel_y, output ready);
endinterface

interface saabb_out_if;
    logic valid;
    logic ready;
    logic hit;
    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

interface saabb_cfg_if;
    logic valid;
    logic ready;
    logic [saabb_pkg::FRAME_WIDTH-1:0] frame_time;
    modport source (output valid, frame_time, input ready);
    modport sink (input valid, frame_time, output ready);
endinterface

// ----- rtl/swept_aabb_collision_test_unit.sv -----
// Swept two-dimensional box contact test, fully pipelined top level.
// Depends on saabb_pkg, the channel interfaces and the assertion macro header.
//
// Usage: a beat on i_box carries two boxes and their velocities in signed Q16.16.
// Each beat yields exactly one beat on o_res whose hit bit says whether the boxes
// overlap now or touch within the frame time held in the configuration register.
// The register is written by a beat on i_cfg, which is always ready; it should
// only be written while no test is in flight.
// The pipeline has three set-up stages, twenty stages of the restoring dividers
// (one quotient bit each, four lanes in parallel) and three stages that combine
// times and form the result. Throughput is one test per cycle while o_res is not
// stalled; the divider chain sets the latency.
// The whole pipeline advances together whenever the output register is empty or
// is being taken, so a stall on o_res holds every stage and lowers i_box.ready;
// nothing is lost or repeated. Reset clears all valid bits and loads the frame
// time with its default of 1092.
`timescale 1ns / 1ps
`include "swept_aabb_collision_test_unit_defines.svh"
module swept_aabb_collision_test_unit #(
    parameter int COORD_WIDTH = saabb_pkg::COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    saabb_in_if.sink    i_box,
    saabb_cfg_if.sink   i_cfg,
    saabb_out_if.source o_res
);
    import saabb_pkg::*;

    // Differences need one extra bit; the partial remainder one more again.
    localparam int DW = COORD_WIDTH + 1;
    localparam int RW = COORD_WIDTH + 2;
    localparam int LANES = 4;

    typedef struct packed {
        logic [RW-1:0]       rem;
        logic [DW-1:0]       den;
        logic [QUO_BITS-1:0] quo;
        logic                sat;
        logic [3:0]          nlo;
    } t_div;

    typedef t_div t_lanes [LANES];

    // One restoring step: bring in the next dividend bit and subtract if possible.
    function automatic t_div div_step(input t_div x);
        t_div         y;
        logic [RW-1:0] t;
        logic          ge;
        t  = {x.rem[RW-2:0], x.nlo[3]};
        ge = (t >= {1'b0, x.den});
        y      = x;
        y.rem  = ge ? t - {1'b0, x.den} : t;
        y.quo  = {x.quo[QUO_BITS-2:0], ge};
        y.nlo  = {x.nlo[2:0], 1'b0};
        return y;
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    function automatic logic [TIME_WIDTH-1:0] quot(input t_div x);
        return x.sat ? TIME_SAT : {1'b0, x.quo};
    endfunction

    logic en;
    logic [FRAME_WIDTH-1:0] r_frame;

    // The pipeline moves as one whenever the output register can take a beat.
    assign en          = !o_res.valid || o_res.ready;
    assign i_box.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= FRAME_RESET;
        end else if (i_cfg.valid) begin
            r_frame <= i_cfg.frame_time;
        end
    end

    // Stage one: edge differences, relative velocities and the static overlap test.
    logic                 r_s1_vld, r_s1_stat;
    logic signed [DW-1:0] r_s1_d1x, r_s1_d2x, r_s1_vbx, r_s1_d1y, r_s1_d2y, r_s1_vby;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_box.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_stat <= !(i_box.a_max_x < i_box.b_min_x || i_box.a_max_y < i_box.b_min_y ||
                           i_box.a_min_x > i_box.b_max_x || i_box.a_min_y > i_box.b_max_y);
            r_s1_d1x  <= DW'(i_box.a_max_x) - DW'(i_box.b_min_x);
            r_s1_d2x  <= DW'(i_box.a_min_x) - DW'(i_box.b_max_x);
            r_s1_vbx  <= DW'(i_box.b_vel_x) - DW'(i_box.a_vel_x);
            r_s1_d1y  <= DW'(i_box.a_max_y) - DW'(i_box.b_min_y);
            r_s1_d2y  <= DW'(i_box.a_min_y) - DW'(i_box.b_max_y);
            r_s1_vby  <= DW'(i_box.b_vel_y) - DW'(i_box.a_vel_y);
        end
    end

    // Stage two: case flags per axis, then magnitudes of the chosen operands.
    // Lanes are entry x, exit x, entry y and exit y in that order.
    logic          r_s2_vld;
    t_flags        r_s2_fl, n_s2_fl;
    logic [DW-1:0] r_s2_num [LANES];
    logic [DW-1:0] r_s2_den [LANES];
    logic [DW-1:0] n_s2_num [LANES];
    logic [DW-1:0] n_s2_den [LANES];

    always_comb begin
        logic negx, posx, negy, posy;
        logic d1nx, d1px, d2nx, d2px, d1ny, d1py, d2ny, d2py;
        negx = r_s1_vbx[DW-1];
        posx = !negx && (r_s1_vbx != '0);
        negy = r_s1_vby[DW-1];
        posy = !negy && (r_s1_vby != '0);
        d1nx = r_s1_d1x[DW-1];
        d1px = !d1nx && (r_s1_d1x != '0);
        d2nx = r_s1_d2x[DW-1];
        d2px = !d2nx && (r_s1_d2x != '0);
        d1ny = r_s1_d1y[DW-1];
        d1py = !d1ny && (r_s1_d1y != '0);
        d2ny = r_s1_d2y[DW-1];
        d2py = !d2ny && (r_s1_d2y != '0);

        n_s2_fl.stat  = r_s1_stat;
        n_s2_fl.missx = negx ? d2px : (posx ? d1nx : (d1nx || d2px));
        n_s2_fl.missy = negy ? d2py : (posy ? d1ny : (d1ny || d2py));
        n_s2_fl.enx   = negx ? d1nx : (posx && d2px);
        n_s2_fl.exx   = negx ? d2nx : (posx && d1px);
        n_s2_fl.eny   = negy ? d1ny : (posy && d2py);
        n_s2_fl.exy   = negy ? d2ny : (posy && d1py);

        n_s2_num[0] = negx ? mag(r_s1_d1x) : mag(r_s1_d2x);
        n_s2_num[1] = negx ? mag(r_s1_d2x) : mag(r_s1_d1x);
        n_s2_num[2] = negy ? mag(r_s1_d1y) : mag(r_s1_d2y);
        n_s2_num[3] = negy ? mag(r_s1_d2y) : mag(r_s1_d1y);
        // A still axis sets no time, so any nonzero divisor will do there.
        n_s2_den[0] = (negx || posx) ? mag(r_s1_vbx) : DW'(1);
        n_s2_den[1] = n_s2_den[0];
        n_s2_den[2] = (negy || posy) ? mag(r_s1_vby) : DW'(1);
        n_s2_den[3] = n_s2_den[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_fl  <= n_s2_fl;
            r_s2_num <= n_s2_num;
            r_s2_den <= n_s2_den;
        end
    end

    // Stage three and the divider chain. Entry zero holds the initial remainder
    // (dividend without its low four bits) and the saturation check: a quotient
    // of sixteen or more is flagged and later replaced by the saturated time.
    logic   r_dv_vld [QUO_BITS+1];
    t_flags r_dv_fl  [QUO_BITS+1];
    t_lanes r_dv     [QUO_BITS+1];
    t_lanes n_dv0;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_dv0[l].rem = RW'(r_s2_num[l] >> 4);
            n_dv0[l].den = r_s2_den[l];
            n_dv0[l].quo = '0;
            n_dv0[l].sat = ((r_s2_num[l] >> 4) >= r_s2_den[l]);
            n_dv0[l].nlo = r_s2_num[l][3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_fl[0] <= r_s2_fl;
            r_dv[0]    <= n_dv0;
        end
    end

    for (genvar k = 1; k <= QUO_BITS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_fl[k] <= r_dv_fl[k-1];
                for (int l = 0; l < LANES; l++) begin
                    r_dv[k][l] <= div_step(r_dv[k-1][l]);
                end
            end
        end
    end

    // Combine stage one: horizontal window, clipped by the frame time, and the vertical entry and exit times.
    logic                  r_c1_vld;
    t_flags                r_c1_fl;
    logic [TIME_WIDTH-1:0] r_c1_tfx, r_c1_tlx, r_c1_ey, r_c1_xy;
    logic [TIME_WIDTH-1:0] qx_en, qx_ex, qy_en, qy_ex, frame_w;

    assign qx_en   = quot(r_dv[QUO_BITS][0]);
    assign qx_ex   = quot(r_dv[QUO_BITS][1]);
    assign qy_en   = quot(r_dv[QUO_BITS][2]);
    assign qy_ex   = quot(r_dv[QUO_BITS][3]);
    assign frame_w = TIME_WIDTH'(r_frame);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
        end else if (en) begin
            r_c1_vld <= r_dv_vld[QUO_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_fl  <= r_dv_fl[QUO_BITS];
            r_c1_tfx <= r_dv_fl[QUO_BITS].enx ? qx_en : '0;
            r_c1_tlx <= (r_dv_fl[QUO_BITS].exx && qx_ex < frame_w) ? qx_ex : frame_w;
            r_c1_ey  <= r_dv_fl[QUO_BITS].eny ? qy_en : '0;
            r_c1_xy  <= r_dv_fl[QUO_BITS].exy ? qy_ex : TIME_SAT;
        end
    end

    // Combine stage two: horizontal verdict and the joint window.
    logic                  r_c2_vld, r_c2_xok;
    t_flags                r_c2_fl;
    logic [TIME_WIDTH-1:0] r_c2_tf, r_c2_tl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_vld <= 1'b0;
        end else if (en) begin
            r_c2_vld <= r_c1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2_fl  <= r_c1_fl;
            r_c2_xok <= (r_c1_tfx <= r_c1_tlx);
            r_c2_tf  <= (r_c1_ey > r_c1_tfx) ? r_c1_ey : r_c1_tfx;
            r_c2_tl  <= (r_c1_xy < r_c1_tlx) ? r_c1_xy : r_c1_tlx;
        end
    end

    // Output register: a static overlap wins; otherwise both axes must agree.
    logic r_ovld, r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_c2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= r_c2_fl.stat || (!r_c2_fl.missx && r_c2_xok && !r_c2_fl.missy &&
                                      (r_c2_tf <= r_c2_tl));
        end
    end

    assign o_res.valid = r_ovld;
    assign o_res.hit   = r_hit;

    `SAABB_ASSERT(a_stall_blocks_input, (o_res.valid && !o_res.ready) |-> !i_box.ready, "input taken during output stall")
    `SAABB_ASSERT(a_static_hit, (en && r_c2_vld && r_c2_fl.stat) |=> (o_res.valid && o_res.hit), "static overlap not reported as hit")
    `SAABB_ASSERT(a_missx_nohit, (en && r_c2_vld && !r_c2_fl.stat && r_c2_fl.missx) |=> !o_res.hit, "receding axis reported as hit")
    `SAABB_ASSERT_RST(a_reset_empty, $past(!i_rst_n) |-> !o_res.valid, "output valid straight after reset")
endmodule

// ----- dv/swept_aabb_collision_checker.sv -----
// Checker for the swept box contact test: watches the box, register and result channels.
// Predicts the hit bit of every accepted box beat and compares it with the result beats.
// Depends on saabb_pkg and the channel interfaces in saabb_ifs.sv.
`timescale 1ns / 1ps
module swept_aabb_collision_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    saabb_in_if.sink    i_box,
    saabb_cfg_if.sink   i_cfg,
    saabb_out_if.sink   i_res,
    output int          o_fail_count,
    output int          o_pending
);
    import saabb_pkg::*;

    localparam logic [63:0] SAT_TIME = 64'h100000;

    logic [FRAME_WIDTH-1:0] frame_len;
    bit hit_queue[$];

    // Unsigned Q5.16 quotient, truncated and saturated at 16.0.
    function automatic logic [63:0] contact_time(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] f;
        f = 0;
        if (d == 0) return SAT_TIME;
        q = n / d;
        if (q >= 16) return SAT_TIME;
        r = n % d;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            f = f << 1;
            if (r >= d) begin
                r = r - d;
                f = f | 1;
            end
        end
        return (q << 16) | f;
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic bit axis_open(input longint amin, input longint amax,
                                     input longint bmin, input longint bmax,
                                     input longint vb, inout logic [63:0] t_in,
                                     inout logic [63:0] t_out);
        logic [63:0] t;
        if (vb < 0) begin
            if (amin > bmax) return 0;
            if (amax < bmin) begin
                t = contact_time(abs64(amax - bmin), abs64(vb));
                if (t > t_in) t_in = t;
            end
            if (amin < bmax) begin
                t = contact_time(abs64(amin - bmax), abs64(vb));
                if (t < t_out) t_out = t;
            end
        end else if (vb > 0) begin
            if (amin > bmax) begin
                t = contact_time(abs64(amin - bmax), abs64(vb));
                if (t > t_in) t_in = t;
            end
            if (amax > bmin) begin
                t = contact_time(abs64(amax - bmin), abs64(vb));
                if (t < t_out) t_out = t;
            end
            if (amax < bmin) return 0;
        end else begin
            if (amax < bmin || amin > bmax) return 0;
        end
        return t_in <= t_out;
    endfunction

    function automatic bit predict_hit();
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, vx, vy;
        logic [63:0] t_in;
        logic [63:0] t_out;
        ax0 = longint'(i_box.a_min_x); ay0 = longint'(i_box.a_min_y);
        ax1 = longint'(i_box.a_max_x); ay1 = longint'(i_box.a_max_y);
        bx0 = longint'(i_box.b_min_x); by0 = longint'(i_box.b_min_y);
        bx1 = longint'(i_box.b_max_x); by1 = longint'(i_box.b_max_y);
        vx = longint'(i_box.b_vel_x) - longint'(i_box.a_vel_x);
        vy = longint'(i_box.b_vel_y) - longint'(i_box.a_vel_y);
        t_in = 0;
        t_out = 64'(frame_len);
        if (!(ax1 < bx0 || ay1 < by0 || ax0 > bx1 || ay0 > by1)) return 1;
        if (!axis_open(ax0, ax1, bx0, bx1, vx, t_in, t_out)) return 0;
        return axis_open(ay0, ay1, by0, by1, vy, t_in, t_out);
    endfunction

    assign o_pending = hit_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_len <= FRAME_RESET;
            o_fail_count <= 0;
            hit_queue.delete();
        end else begin
            if (i_box.valid && i_box.ready) hit_queue.push_back(predict_hit());
            if (i_res.valid && i_res.ready) begin
                if (hit_queue.size() == 0) begin
                    $display("%0t: result beat with none expected, actual hit %0b",
                             $time, i_res.hit);
                    o_fail_count <= o_fail_count + 1;
                end else if (hit_queue[0] !== i_res.hit) begin
                    $display("%0t: hit mismatch, expected %0b actual %0b",
                             $time, hit_queue[0], i_res.hit);
                    o_fail_count <= o_fail_count + 1;
                    void'(hit_queue.pop_front());
                end else begin
                    void'(hit_queue.pop_front());
                end
            end
            if (i_cfg.valid && i_cfg.ready) frame_len <= i_cfg.frame_time;
        end
    end
endmodule

// ----- dv/tb_swept_aabb_collision_test_unit.sv -----
// Testbench top for the swept box contact test: clock, reset, stimulus and verdict.
// Depends on saabb_pkg, the channel interfaces, the unit and the checker module.
`timescale 1ns / 1ps
module tb_swept_aabb_collision_test_unit;
    import saabb_pkg::*;

    // The pipeline is 26 stages deep; drain with ample margin before each register write.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_BOXES = 1600;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   steady_stretch;

    saabb_in_if  box_ch ();
    saabb_cfg_if cfg_ch ();
    saabb_out_if res_ch ();

    swept_aabb_collision_test_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_box   (box_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    swept_aabb_collision_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_box        (box_ch.sink),
        .i_cfg        (cfg_ch.sink),
        .i_res        (res_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A box pair in the order of the interface fields.
    typedef logic signed [31:0] coord_t;
    typedef struct {
        coord_t ax0, ay0, ax1, ay1, avx, avy, bx0, by0, bx1, by1, bvx, bvy;
    } box_pair_t;

    // The result side stalls about 14 beats in a hundred, except in the steady stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= steady_stretch || ($urandom_range(99) >= 14);
        end
    end

    // Holds one beat on the box channel until it is accepted. Inputs change only on
    // the falling edge, so the checker sees a stable beat at every rising edge.
    task automatic send_pair(input box_pair_t p);
        while (!steady_stretch && $urandom_range(99) < 14) begin
            box_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        box_ch.a_min_x <= p.ax0; box_ch.a_min_y <= p.ay0;
        box_ch.a_max_x <= p.ax1; box_ch.a_max_y <= p.ay1;
        box_ch.a_vel_x <= p.avx; box_ch.a_vel_y <= p.avy;
        box_ch.b_min_x <= p.bx0; box_ch.b_min_y <= p.by0;
        box_ch.b_max_x <= p.bx1; box_ch.b_max_y <= p.by1;
        box_ch.b_vel_x <= p.bvx; box_ch.b_vel_y <= p.bvy;
        box_ch.valid   <= 1'b1;
        @(posedge i_clk);
        while (!box_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Waits until every expected beat has come back, then lets the pipeline drain so
    // the register can be written with nothing in flight.
    task automatic write_frame_time(input logic [FRAME_WIDTH-1:0] value);
        box_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_ch.frame_time <= value;
        cfg_ch.valid      <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random coordinate: mostly small values near the origin so that boxes meet within
    // a frame, with the occasional full-range value to reach the extremes.
    function automatic coord_t pick_coord(input int spread);
        if ($urandom_range(15) == 0) return coord_t'($urandom);
        return coord_t'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    function automatic box_pair_t random_pair();
        box_pair_t p;
        int sp;
        int vs;
        sp = 32'h0010_0000 >> $urandom_range(6);
        vs = 32'h0400_0000 >> $urandom_range(10);
        p.ax0 = pick_coord(sp); p.ay0 = pick_coord(sp);
        p.bx0 = pick_coord(sp); p.by0 = pick_coord(sp);
        // Well-formed boxes most of the time; inverted ones now and then.
        if ($urandom_range(9) != 0) begin
            p.ax1 = p.ax0 + coord_t'($urandom_range(sp / 4));
            p.ay1 = p.ay0 + coord_t'($urandom_range(sp / 4));
            p.bx1 = p.bx0 + coord_t'($urandom_range(sp / 4));
            p.by1 = p.by0 + coord_t'($urandom_range(sp / 4));
        end else begin
            p.ax1 = pick_coord(sp); p.ay1 = pick_coord(sp);
            p.bx1 = pick_coord(sp); p.by1 = pick_coord(sp);
        end
        p.avx = pick_coord(vs); p.avy = pick_coord(vs);
        p.bvx = pick_coord(vs); p.bvy = pick_coord(vs);
        // Zero relative velocity on one axis is a special case worth hitting often.
        if ($urandom_range(7) == 0) p.bvx = p.avx;
        if ($urandom_range(7) == 0) p.bvy = p.avy;
        return p;
    endfunction

    function automatic box_pair_t make_pair(input coord_t ax0, input coord_t ax1,
                                            input coord_t bx0, input coord_t bx1,
                                            input coord_t vx, input coord_t vy);
        box_pair_t p;
        p = '{ax0, 0, ax1, 32'h0001_0000, 0, 0, bx0, 0, bx1, 32'h0001_0000, vx, vy};
        return p;
    endfunction

    task automatic run_directed();
        box_pair_t p;
        // Overlapping, and merely touching at an edge.
        send_pair(make_pair(0, 32'h10000, 32'h8000, 32'h20000, 0, 0));
        send_pair(make_pair(0, 32'h10000, 32'h10000, 32'h20000, 0, 0));
        // Separated with zero relative velocity: a miss.
        send_pair(make_pair(0, 32'h10000, 32'h20000, 32'h30000, 0, 0));
        // B to the right moving left quickly: a hit within a frame.
        send_pair(make_pair(0, 32'h10000, 32'h18000, 32'h20000, 32'hFF80_0000, 0));
        // The same but too slow for the reset frame time.
        send_pair(make_pair(0, 32'h10000, 32'h18000, 32'h20000, 32'hFFFF_0000, 0));
        // B to the right moving away: receding miss.
        send_pair(make_pair(0, 32'h10000, 32'h20000, 32'h30000, 32'h0100_0000, 0));
        // B to the left moving right, and moving left.
        send_pair(make_pair(32'h20000, 32'h30000, 0, 32'h10000, 32'h0100_0000, 0));
        send_pair(make_pair(32'h20000, 32'h30000, 0, 32'h10000, 32'hFF00_0000, 0));
        // Separated on y only, with vertical approach and with zero vertical speed.
        p = '{0, 0, 32'h10000, 32'h10000, 0, 0, 0, 32'h18000, 32'h10000, 32'h20000,
              0, 32'hFF80_0000};
        send_pair(p);
        p.bvy = 0;
        send_pair(p);
        // Inverted box A.
        send_pair(make_pair(32'h10000, 0, 32'h20000, 32'h30000, 32'hFF00_0000, 0));
        // Extremes of every field, and velocity extremes in opposite directions.
        p = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_pair(p);
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF));
        send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000));
        send_pair('{default: 32'hFFFF_FFFF});
        send_pair('{default: 32'h0});
    endtask

    initial begin
        logic [FRAME_WIDTH-1:0] settings[6];
        settings = '{FRAME_RESET, 20'h0, 20'hF_FFFF, 20'h1_0000, 20'h0_0444, 20'h0_4000};
        steady_stretch = 1'b0;
        i_rst_n = 1'b0;
        box_ch.valid = 1'b0;
        {box_ch.a_min_x, box_ch.a_min_y, box_ch.a_max_x, box_ch.a_max_y,
         box_ch.a_vel_x, box_ch.a_vel_y, box_ch.b_min_x, box_ch.b_min_y,
         box_ch.b_max_x, box_ch.b_max_y, box_ch.b_vel_x, box_ch.b_vel_y} = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.frame_time = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed cases at the reset frame time first, then at a long frame.
        run_directed();
        write_frame_time(20'hF_FFFF);
        run_directed();

        // Random phases, each under its own frame time; one phase runs without idling.
        for (int ph = 0; ph < 6; ph++) begin
            write_frame_time(ph == 5 ? FRAME_WIDTH'($urandom_range(20'hF_FFFF))
                                     : settings[ph]);
            steady_stretch = (ph == 3);
            for (int n = 0; n < RANDOM_BOXES / 6; n++) send_pair(random_pair());
            steady_stretch = 1'b0;
        end
        box_ch.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/saabb_pkg.sv
rtl/saabb_ifs.sv
rtl/swept_aabb_collision_test_unit.sv
dv/swept_aabb_collision_checker.sv
dv/tb_swept_aabb_collision_test_unit.sv
